// ===== sv/mcrc_pkg.sv =====
// Package for the masked code rule classifier: sizes, codes, entry types.
// No dependencies.
package mcrc_pkg;
	localparam int RULES = 64;
	localparam int SELECTORS = 256;
	localparam int RW = $clog2(RULES);
	localparam int SW = $clog2(SELECTORS);

	localparam logic [1:0] CMD_CLASSIFY = 2'd0;
	localparam logic [1:0] CMD_RULE = 2'd1;
	localparam logic [1:0] CMD_SEL = 2'd2;

	localparam logic [1:0] KIND_ANY = 2'd0;
	localparam logic [1:0] KIND_MASKED = 2'd1;
	localparam logic [1:0] KIND_EXACT = 2'd2;

	localparam logic [1:0] CH_FIRST = 2'd1;
	localparam logic [1:0] CH_SECOND = 2'd2;

	localparam logic [1:0] ACT_PAUSE = 2'd0;
	localparam logic [1:0] ACT_BAD = 2'd3;

	localparam logic [2:0] SRC_DISABLED = 3'd0;
	localparam logic [2:0] SRC_RULE = 3'd1;
	localparam logic [2:0] SRC_FIRST = 3'd2;
	localparam logic [2:0] SRC_SECOND = 3'd3;
	localparam logic [2:0] SRC_ACK = 3'd4;

	localparam logic [1:0] REG_POLICY = 2'd0;
	localparam logic [1:0] REG_FIRST = 2'd1;
	localparam logic [1:0] REG_SECOND = 2'd2;

	typedef struct packed {
		logic enabled;
		logic [1:0] chance;
		logic [1:0] action;
		logic signed [15:0] prio;
		logic [31:0] order;
	} rule_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [5:0] bits;
		logic [5:0] owner;
		logic [31:0] value;
		logic [31:0] smask;
	} sel_t;

	function automatic logic [1:0] clean_action(logic [1:0] a);
		return (a == ACT_BAD) ? ACT_PAUSE : a;
	endfunction
endpackage

// ===== sv/mcrc_if.sv =====
// Valid/ready channel interfaces for the classifier's request, result and config.
// No dependencies.
interface mcrc_req_if;
	logic valid;
	logic ready;
	logic [1:0] cmd;
	logic [7:0] entry_index;
	logic [31:0] code;
	logic [31:0] mask;
	logic first_chance;
	logic entry_enabled;
	logic [1:0] chance;
	logic [1:0] rule_action;
	logic signed [15:0] priority_req;
	logic [31:0] insert_order;
	logic [1:0] selector_kind;
	logic [5:0] owner_rule;
	modport source(output valid, cmd, entry_index, code, mask, first_chance,
		entry_enabled, chance, rule_action, priority_req, insert_order,
		selector_kind, owner_rule, input ready);
	modport sink(input valid, cmd, entry_index, code, mask, first_chance,
		entry_enabled, chance, rule_action, priority_req, insert_order,
		selector_kind, owner_rule, output ready);
endinterface

interface mcrc_res_if;
	logic valid;
	logic ready;
	logic matched;
	logic [1:0] action;
	logic [2:0] src;
	logic [5:0] rule_index;
	logic [7:0] selector_index;
	logic [5:0] mask_bits;
	modport source(output valid, matched, action, src, rule_index,
		selector_index, mask_bits, input ready);
	modport sink(input valid, matched, action, src, rule_index,
		selector_index, mask_bits, output ready);
endinterface

interface mcrc_cfg_if;
	logic valid;
	logic ready;
	logic [1:0] index;
	logic [1:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// ===== sv/mcrc_ram.sv =====
// Generic single-port-write, one-read synchronous RAM with registered read.
// No dependencies.
module mcrc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

// ===== sv/masked_code_rule_classifier.sv =====
// Top level of the masked code rule classifier.
// Depends on mcrc_pkg, mcrc_if and mcrc_ram.

// A write request is answered from the result register with no scan. For a
// classify request the selector memory is read one slot a cycle, the owner rule
// is read from the rule memory the cycle after, and the candidate is compared
// against the best so far the cycle after that; the scan is left once the
// pipeline is empty, and the done state loads the result.
// One request is worked at a time; the result register frees the input side
// once taken, so a stalled result stalls the input too. Selector valid bits are
// flip-flops cleared at reset; no clearing pass.
module masked_code_rule_classifier import mcrc_pkg::*; (
	input logic clk,
	input logic arst_n,
	mcrc_req_if.sink req,
	mcrc_res_if.source res,
	mcrc_cfg_if.sink cfg
);
	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_DONE = 3'b100
	} state_t;

	state_t state_q;
	logic policy_q;
	logic [1:0] first_def_q, second_def_q;
	logic [SELECTORS-1:0] sel_valid_q;

	// captured classify request
	logic [31:0] code_q;
	logic first_q;
	logic [SW:0] scan_q;

	// pipeline: s1 = selector read out, s2 = rule read out
	logic run_s1, run_s2;
	logic [SW-1:0] slot_s1, slot_s2;
	logic valid_s2;
	sel_t sel_s2;

	// best candidate
	logic found_q;
	logic [1:0] bkind_q;
	logic [5:0] bbits_q;
	logic signed [15:0] bprio_q;
	logic [31:0] border_q;
	logic [1:0] bact_q;
	logic [5:0] brule_q;
	logic [SW-1:0] bslot_q;

	logic accept, sel_we, rule_we;
	sel_t sel_wdata, sel_rdata;
	rule_t rule_wdata, rule_rdata;
	logic [1:0] wkind;

	assign cfg.ready = 1'b1;
	assign req.ready = (state_q == ST_IDLE) && !res.valid;
	assign accept = req.valid && req.ready;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q <= 1'b1;
			first_def_q <= ACT_PAUSE;
			second_def_q <= ACT_PAUSE;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_POLICY: policy_q <= cfg.data[0];
				REG_FIRST: first_def_q <= cfg.data;
				REG_SECOND: second_def_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// write data formatting
	assign wkind = (req.selector_kind == 2'd3) ? KIND_ANY : req.selector_kind;
	always_comb begin
		sel_wdata.kind = wkind;
		sel_wdata.owner = req.owner_rule;
		case (wkind)
			KIND_EXACT: begin
				sel_wdata.value = req.code;
				sel_wdata.smask = '1;
				sel_wdata.bits = 6'd32;
			end
			KIND_MASKED: begin
				sel_wdata.value = req.code & req.mask;
				sel_wdata.smask = req.mask;
				sel_wdata.bits = 6'($countones(req.mask));
			end
			default: begin
				sel_wdata.value = '0;
				sel_wdata.smask = '0;
				sel_wdata.bits = '0;
			end
		endcase
		rule_wdata.enabled = req.entry_enabled;
		rule_wdata.chance = req.chance;
		rule_wdata.action = clean_action(req.rule_action);
		rule_wdata.prio = req.priority_req;
		rule_wdata.order = req.insert_order;
	end

	assign sel_we = accept && req.cmd == CMD_SEL && 9'(req.entry_index) < 9'(SELECTORS);
	assign rule_we = accept && req.cmd == CMD_RULE && 9'(req.entry_index) < 9'(RULES);

	mcrc_ram #(.WIDTH($bits(sel_t)), .DEPTH(SELECTORS)) u_sel_ram (
		.clk(clk), .we(sel_we), .waddr(req.entry_index[SW-1:0]),
		.wdata(sel_wdata), .raddr(scan_q[SW-1:0]), .rdata(sel_rdata)
	);

	mcrc_ram #(.WIDTH($bits(rule_t)), .DEPTH(RULES)) u_rule_ram (
		.clk(clk), .we(rule_we), .waddr(req.entry_index[RW-1:0]),
		.wdata(rule_wdata), .raddr(sel_rdata.owner[RW-1:0]), .rdata(rule_rdata)
	);

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) sel_valid_q <= '0;
		else if (sel_we) sel_valid_q[req.entry_index[SW-1:0]] <= req.entry_enabled;
	end

	// candidate evaluation at s2
	logic hit, better, eligible;
	logic [5:0] cbits;
	always_comb begin
		eligible = valid_s2 && 7'(sel_s2.owner) < 7'(RULES) && rule_rdata.enabled
			&& !(rule_rdata.chance == CH_FIRST && !first_q)
			&& !(rule_rdata.chance == CH_SECOND && first_q);
		hit = ((code_q & sel_s2.smask) == (sel_s2.value & sel_s2.smask));
		cbits = (sel_s2.kind == KIND_MASKED) ? sel_s2.bits : 6'd0;
		if (!found_q) better = 1'b1;
		else if (sel_s2.kind != bkind_q) better = sel_s2.kind > bkind_q;
		else if (cbits != bbits_q) better = cbits > bbits_q;
		else if (rule_rdata.prio != bprio_q) better = rule_rdata.prio > bprio_q;
		else better = rule_rdata.order < border_q;
	end

	// sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			res.valid <= 1'b0;
			run_s1 <= 1'b0;
			run_s2 <= 1'b0;
			found_q <= 1'b0;
			scan_q <= '0;
		end else begin
			if (res.valid && res.ready) res.valid <= 1'b0;
			run_s1 <= state_q == ST_SCAN && scan_q < (SW+1)'(SELECTORS);
			run_s2 <= run_s1;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (req.cmd != CMD_CLASSIFY || !policy_q) begin
							res.valid <= 1'b1;
							res.matched <= 1'b0;
							res.action <= ACT_PAUSE;
							res.src <= (req.cmd != CMD_CLASSIFY) ? SRC_ACK : SRC_DISABLED;
							res.rule_index <= '0;
							res.selector_index <= '0;
							res.mask_bits <= '0;
						end else begin
							state_q <= ST_SCAN;
							code_q <= req.code;
							first_q <= req.first_chance;
							scan_q <= '0;
							found_q <= 1'b0;
						end
					end
				end
				ST_SCAN: begin
					if (scan_q < (SW+1)'(SELECTORS)) scan_q <= scan_q + 1'b1;
					else if (!run_s1 && !run_s2) state_q <= ST_DONE;
				end
				ST_DONE: begin
					state_q <= ST_IDLE;
					res.valid <= 1'b1;
					res.matched <= found_q;
					res.rule_index <= found_q ? brule_q : 6'd0;
					res.selector_index <= found_q ? 8'(bslot_q) : 8'd0;
					res.mask_bits <= found_q ? bbits_q : 6'd0;
					if (found_q) begin
						res.action <= bact_q;
						res.src <= SRC_RULE;
					end else if (first_q) begin
						res.action <= clean_action(first_def_q);
						res.src <= SRC_FIRST;
					end else begin
						res.action <= clean_action(second_def_q);
						res.src <= SRC_SECOND;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (run_s2 && eligible && hit && better) found_q <= 1'b1;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		slot_s1 <= scan_q[SW-1:0];
		slot_s2 <= slot_s1;
		valid_s2 <= run_s1 && sel_valid_q[slot_s1];
		sel_s2 <= sel_rdata;
		if (run_s2 && eligible && hit && better) begin
			bkind_q <= sel_s2.kind;
			bbits_q <= cbits;
			bprio_q <= rule_rdata.prio;
			border_q <= rule_rdata.order;
			bact_q <= rule_rdata.action;
			brule_q <= sel_s2.owner;
			bslot_q <= slot_s2;
		end
	end
endmodule

// ===== sv/mcrc_checker.sv =====
// Port-level checker for the masked code rule classifier, bound to the top.
// Depends on mcrc_pkg and, through the bind, on the classifier top.
module mcrc_checker import mcrc_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input logic res_valid,
	input logic res_ready,
	input logic matched,
	input logic [2:0] source,
	input logic [1:0] action,
	input logic [5:0] mask_bits
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(source))
		else $error("result dropped while stalled");
	a_match_src: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> matched == (source == SRC_RULE))
		else $error("matched disagrees with source");
	a_nomatch_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !matched |-> mask_bits == 6'd0)
		else $error("mask bits on unmatched result");
	a_no_take: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !req_ready)
		else $error("request taken while result pending");
	a_action: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> action != ACT_BAD)
		else $error("illegal action code");
endmodule

bind masked_code_rule_classifier mcrc_checker u_mcrc_checker (
	.clk(clk), .arst_n(arst_n), .req_valid(req.valid), .req_ready(req.ready),
	.res_valid(res.valid), .res_ready(res.ready), .matched(res.matched),
	.source(res.src), .action(res.action), .mask_bits(res.mask_bits)
);

// ===== bench/tb_mcrc_score.sv =====
// Scoreboard for the masked code rule classifier bench: predicts each request's
// result from a private copy of the tables and checks results in order. Needs mcrc_pkg.
package tb_mcrc_score_pkg;
	import mcrc_pkg::*;

	typedef struct packed {
		logic [1:0] cmd;
		logic [7:0] entry_index;
		logic [31:0] code;
		logic [31:0] mask;
		logic first_chance;
		logic entry_enabled;
		logic [1:0] chance;
		logic [1:0] rule_action;
		logic signed [15:0] priority_req;
		logic [31:0] insert_order;
		logic [1:0] selector_kind;
		logic [5:0] owner_rule;
	} request_t;

	typedef struct packed {
		logic matched;
		logic [1:0] action;
		logic [2:0] source;
		logic [5:0] rule_index;
		logic [7:0] selector_index;
		logic [5:0] mask_bits;
	} verdict_t;

	class classifier_scoreboard;
		bit rule_on[RULES];
		bit [1:0] rule_ch[RULES];
		bit [1:0] rule_act[RULES];
		bit signed [15:0] rule_prio[RULES];
		bit [31:0] rule_ord[RULES];
		bit sel_valid[SELECTORS];
		bit [1:0] sel_kind[SELECTORS];
		bit [5:0] sel_bits[SELECTORS];
		bit [5:0] sel_owner[SELECTORS];
		bit [31:0] sel_value[SELECTORS];
		bit [31:0] sel_mask[SELECTORS];
		bit policy_on = 1;
		bit [1:0] first_dflt = 0, second_dflt = 0;
		verdict_t pending[$];
		int errors = 0;

		function bit [1:0] tidy_action(bit [1:0] a);
			return a == ACT_BAD ? ACT_PAUSE : a;
		endfunction

		function void set_register(bit [1:0] idx, bit [1:0] val);
			if (idx == REG_POLICY) policy_on = val[0];
			else if (idx == REG_FIRST) first_dflt = val;
			else if (idx == REG_SECOND) second_dflt = val;
		endfunction

		// predict the answer to one accepted request and queue it
		function void note_request(request_t r);
			verdict_t v;
			bit found, hit, better;
			int best_slot, best_rule;
			bit [1:0] best_kind, k;
			bit [5:0] best_bits, bits;
			int o;
			v = '0;
			v.source = SRC_ACK;
			if (r.cmd == CMD_RULE) begin
				if (r.entry_index < RULES) begin
					rule_on[r.entry_index] = r.entry_enabled;
					rule_ch[r.entry_index] = r.chance;
					rule_act[r.entry_index] = tidy_action(r.rule_action);
					rule_prio[r.entry_index] = r.priority_req;
					rule_ord[r.entry_index] = r.insert_order;
				end
			end else if (r.cmd == CMD_SEL) begin
				k = (r.selector_kind == 2'd3) ? KIND_ANY : r.selector_kind;
				sel_valid[r.entry_index] = r.entry_enabled;
				sel_kind[r.entry_index] = k;
				sel_owner[r.entry_index] = r.owner_rule;
				sel_value[r.entry_index] = k == KIND_EXACT ? r.code :
					k == KIND_MASKED ? (r.code & r.mask) : 32'd0;
				sel_mask[r.entry_index] = k == KIND_EXACT ? 32'hFFFF_FFFF :
					k == KIND_MASKED ? r.mask : 32'd0;
				sel_bits[r.entry_index] = k == KIND_EXACT ? 6'd32 :
					k == KIND_MASKED ? 6'($countones(r.mask)) : 6'd0;
			end else if (r.cmd == CMD_CLASSIFY) begin
				if (!policy_on) begin
					v.source = SRC_DISABLED;
				end else begin
					found = 0;
					best_slot = 0; best_rule = 0; best_kind = 0; best_bits = 0;
					for (int i = 0; i < SELECTORS; i++) begin
						o = sel_owner[i];
						if (!sel_valid[i] || o >= RULES || !rule_on[o]) continue;
						if (rule_ch[o] == CH_FIRST && !r.first_chance) continue;
						if (rule_ch[o] == CH_SECOND && r.first_chance) continue;
						hit = (r.code & sel_mask[i]) == (sel_value[i] & sel_mask[i]);
						if (!hit) continue;
						bits = sel_kind[i] == KIND_MASKED ? sel_bits[i] : 6'd0;
						if (!found) better = 1;
						else if (sel_kind[i] != best_kind) better = sel_kind[i] > best_kind;
						else if (bits != best_bits) better = bits > best_bits;
						else if (rule_prio[o] != rule_prio[best_rule])
							better = rule_prio[o] > rule_prio[best_rule];
						else better = rule_ord[o] < rule_ord[best_rule];
						if (better) begin
							found = 1; best_slot = i; best_rule = o;
							best_kind = sel_kind[i]; best_bits = bits;
						end
					end
					if (found) begin
						v.matched = 1;
						v.action = rule_act[best_rule];
						v.source = SRC_RULE;
						v.rule_index = 6'(best_rule);
						v.selector_index = 8'(best_slot);
						v.mask_bits = best_bits;
					end else begin
						v.action = tidy_action(r.first_chance ? first_dflt : second_dflt);
						v.source = r.first_chance ? SRC_FIRST : SRC_SECOND;
					end
				end
			end
			pending = {pending, v};
		endfunction

		// compare one result with the oldest prediction
		function void check_result(verdict_t got);
			verdict_t want;
			if (pending.size() == 0) begin
				$error("result with nothing outstanding: %p", got);
				errors++;
				return;
			end
			want = pending.pop_front();
			if (got.matched !== want.matched) begin
				$error("matched: expected %0d got %0d", want.matched, got.matched); errors++;
			end
			if (got.action !== want.action) begin
				$error("action: expected %0d got %0d", want.action, got.action); errors++;
			end
			if (got.source !== want.source) begin
				$error("source: expected %0d got %0d", want.source, got.source); errors++;
			end
			if (got.rule_index !== want.rule_index) begin
				$error("rule_index: expected %0d got %0d", want.rule_index, got.rule_index);
				errors++;
			end
			if (got.selector_index !== want.selector_index) begin
				$error("selector_index: expected %0d got %0d", want.selector_index,
					got.selector_index);
				errors++;
			end
			if (got.mask_bits !== want.mask_bits) begin
				$error("mask_bits: expected %0d got %0d", want.mask_bits, got.mask_bits);
				errors++;
			end
		endfunction
	endclass
endpackage

// ===== bench/tb.sv =====
// Top of the classifier bench: clock, reset, request/result/config drivers, watchdog.
// Depends on mcrc_pkg, mcrc_if, tb_mcrc_score_pkg and the classifier RTL.
module tb;
	import mcrc_pkg::*;
	import tb_mcrc_score_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int IDLE_LIMIT = 20000;

	logic clk = 0;
	logic arst_n = 0;
	mcrc_req_if req();
	mcrc_res_if res();
	mcrc_cfg_if cfg();

	masked_code_rule_classifier dut (.clk(clk), .arst_n(arst_n), .req(req), .res(res),
		.cfg(cfg));

	classifier_scoreboard board = new();
	bit calm = 0;          // no idling on either side
	bit hold_results = 0;  // long receiver hold-off request
	int quiet = 0;
	bit [31:0] known_codes[8];
	int written_rules[$];

	initial forever #5 clk = ~clk;

	// send one request, with a random idle gap first unless calm
	task automatic send(request_t r);
		@(posedge clk);
		while (!calm && $urandom_range(99) < 23) @(posedge clk);
		req.valid <= 1;
		{req.cmd, req.entry_index, req.code, req.mask, req.first_chance, req.entry_enabled,
			req.chance, req.rule_action, req.priority_req, req.insert_order,
			req.selector_kind, req.owner_rule} <= r;
		do @(posedge clk); while (!req.ready);
		board.note_request(r);
		req.valid <= 0;
	endtask

	task automatic drain();
		while (board.pending.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(bit [1:0] idx, bit [1:0] val);
		drain();
		cfg.valid <= 1; cfg.index <= idx; cfg.data <= val;
		do @(posedge clk); while (!cfg.ready);
		board.set_register(idx, val);
		cfg.valid <= 0;
	endtask

	task automatic put_rule(int idx, bit on, bit [1:0] ch, bit [1:0] act,
			bit [15:0] prio, bit [31:0] ord);
		request_t r = '0;
		r.cmd = CMD_RULE; r.entry_index = 8'(idx); r.entry_enabled = on; r.chance = ch;
		r.rule_action = act; r.priority_req = prio; r.insert_order = ord;
		r.code = $urandom(); r.mask = $urandom();
		if (idx < RULES) written_rules = {written_rules, idx};
		send(r);
	endtask

	task automatic put_sel(int slot, bit on, bit [1:0] kind, bit [31:0] value,
			bit [31:0] m, bit [5:0] owner);
		request_t r = '0;
		r.cmd = CMD_SEL; r.entry_index = 8'(slot); r.entry_enabled = on;
		r.selector_kind = kind; r.code = value; r.mask = m; r.owner_rule = owner;
		send(r);
	endtask

	task automatic classify(bit [31:0] c, bit first);
		request_t r = '0;
		r.cmd = CMD_CLASSIFY; r.code = c; r.first_chance = first;
		r.mask = $urandom(); r.entry_index = 8'($urandom());
		send(r);
	endtask

	// random mix of rule writes, selector writes owned by written rules, unknown commands and classifies
	task automatic random_phase(int n);
		request_t r;
		int pick;
		for (int i = 0; i < n; i++) begin
			pick = $urandom_range(99);
			if (pick < 15) begin
				put_rule($urandom_range(RULES - 1), $urandom_range(99) < 80, $urandom_range(3),
					$urandom_range(3), 16'($urandom()), $urandom());
			end else if (pick < 35) begin
				put_sel($urandom_range(SELECTORS - 1), $urandom_range(99) < 75,
					$urandom_range(3), known_codes[$urandom_range(7)] ^
					($urandom_range(1) ? 0 : $urandom()), $urandom_range(1) ? $urandom() :
					32'hFFFF_0000 >> $urandom_range(16),
					6'(written_rules[$urandom_range(written_rules.size() - 1)]));
			end else if (pick < 37) begin
				r = '0;
				r.cmd = 2'd3;
				{r.code, r.mask} = {$urandom(), $urandom()};
				send(r);
			end else begin
				classify($urandom_range(2) ? known_codes[$urandom_range(7)] ^
					(32'h1 << $urandom_range(31)) * $urandom_range(1) : $urandom(),
					$urandom_range(1));
			end
		end
	endtask

	// result side: random stalls, plus the long hold-off
	initial begin
		verdict_t got;
		res.ready = 0;
		forever begin
			@(posedge clk);
			if (res.valid && res.ready) begin
				got = {res.matched, res.action, res.src, res.rule_index,
					res.selector_index, res.mask_bits};
				board.check_result(got);
			end
			res.ready <= !hold_results && (calm || $urandom_range(99) >= 23);
		end
	end

	// watchdog on accepted traffic
	initial begin
		forever begin
			@(posedge clk);
			if ((req.valid && req.ready) || (res.valid && res.ready) ||
					(cfg.valid && cfg.ready) || hold_results)
				quiet = 0;
			else
				quiet++;
			if (quiet >= IDLE_LIMIT) begin
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	initial begin
		req.valid = 0; req.cmd = CMD_CLASSIFY; req.entry_index = 0; req.code = 0;
		req.mask = 0; req.first_chance = 0; req.entry_enabled = 0; req.chance = 0;
		req.rule_action = 0; req.priority_req = 0; req.insert_order = 0;
		req.selector_kind = 0; req.owner_rule = 0;
		cfg.valid = 0; cfg.index = REG_POLICY; cfg.data = 0;
		for (int i = 0; i < 8; i++) known_codes[i] = $urandom();
		known_codes[0] = 32'h0; known_codes[1] = 32'hFFFF_FFFF;
		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: extremes, every command and each corner
		put_rule(0, 1, 0, 1, 16'sh7FFF, 0);
		put_rule(63, 1, CH_FIRST, 2, 16'sh8000, 32'hFFFF_FFFF);
		put_rule(5, 1, CH_SECOND, ACT_BAD, 0, 7);
		put_rule(6, 1, 2'd3, 2, 0, 6);
		put_rule(7, 0, 0, 1, 100, 1);
		put_rule(200, 1, 0, 1, 0, 0);  // out of range rule: ack only
		classify(32'h1234, 1);         // nothing valid: default
		put_sel(0, 1, KIND_ANY, 0, 0, 0);
		put_sel(255, 1, KIND_EXACT, 32'hFFFF_FFFF, 0, 63);
		put_sel(10, 1, KIND_MASKED, 32'hABCD_0000, 32'hFFFF_0000, 5);
		put_sel(11, 1, KIND_MASKED, 32'h0, 32'h0, 6);     // zero mask
		put_sel(12, 1, 2'd3, 32'h55, 32'h1, 7);           // stored as wildcard, rule off
		put_sel(13, 1, KIND_EXACT, 32'h1, 0, 50);         // owner never written: invalid...
		put_sel(13, 0, KIND_EXACT, 32'h1, 0, 50);         // ...so cleared again
		classify(32'hFFFF_FFFF, 1);
		classify(32'hFFFF_FFFF, 0);
		classify(32'hABCD_1234, 0);
		classify(32'hABCD_1234, 1);
		classify(32'h0, 0);
		begin
			request_t r = '0;
			r.cmd = 2'd3; r.code = '1; r.mask = '1;
			send(r);
		end
		written_rules = {written_rules, 5, 6};

		// default actions and policy off
		write_reg(REG_FIRST, 2); write_reg(REG_SECOND, 3);
		put_sel(0, 0, KIND_ANY, 0, 0, 0);
		classify(32'h42, 1); classify(32'h42, 0);
		write_reg(REG_POLICY, 0);
		classify(32'hFFFF_FFFF, 1);
		put_rule(1, 1, 0, 1, 5, 3);
		write_reg(REG_POLICY, 1);

		// random phases through several register settings
		for (int p = 0; p < 6; p++) begin
			calm = (p == 2);
			if (p == 3) fork
				begin hold_results = 1; repeat (3000) @(posedge clk); hold_results = 0; end
				random_phase(40);
			join else random_phase(325);
			drain();
			write_reg(REG_POLICY, p != 4);
			write_reg(REG_FIRST, $urandom_range(3));
			write_reg(REG_SECOND, $urandom_range(3));
		end
		write_reg(REG_POLICY, 1);
		random_phase(60);

		drain();
		if (board.errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule
